// ===== rtl/core/kvsq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register map, reset values and constant-divide helpers.
package kvsq_pkg;

  localparam int ADC_BITS    = 12;
  localparam int PERIOD_BITS = 8;
  localparam int LEVEL_BITS  = 8;
  localparam int AUDIO_BITS  = 6;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;

  typedef struct packed {
    logic [ADC_BITS-1:0]    adc_low;
    logic [ADC_BITS-1:0]    adc_high;
    logic [PERIOD_BITS-1:0] update_period;
    logic [LEVEL_BITS-1:0]  audio_threshold;
  } kvsq_cfg_t;

  typedef enum logic [1:0] {
    REG_ADC_LOW         = 2'd0,
    REG_ADC_HIGH        = 2'd1,
    REG_UPDATE_PERIOD   = 2'd2,
    REG_AUDIO_THRESHOLD = 2'd3
  } kvsq_reg_t;

  localparam logic [ADC_BITS-1:0]    RST_ADC_LOW         = 12'd2162;
  localparam logic [ADC_BITS-1:0]    RST_ADC_HIGH        = 12'd4086;
  localparam logic [PERIOD_BITS-1:0] RST_UPDATE_PERIOD   = 8'd25;
  localparam logic [LEVEL_BITS-1:0]  RST_AUDIO_THRESHOLD = 8'd70;

  // x / 10 == (x * 52429) >> 19, exact for any 16-bit x
  localparam int DIV10_MUL_BITS = 16;
  localparam logic [DIV10_MUL_BITS-1:0] DIV10_MUL = 16'd52429;
  localparam int DIV10_SHIFT = 19;

  // level = n / 99 with n = 5 * d; (n * 5295) >> 19 is low by at most one
  localparam int DIV99_MUL_BITS = 13;
  localparam logic [DIV99_MUL_BITS-1:0] DIV99_MUL = 13'd5295;
  localparam int DIV99_SHIFT = 19;
  localparam logic [6:0] LEVEL_DIVISOR = 7'd99;

  // x / 5 for 8-bit x: (x * 205) >> 10, exact over 0..255
  function automatic logic [AUDIO_BITS-1:0] div5_u8(input logic [LEVEL_BITS-1:0] x);
    logic [15:0] prod;
    prod = {8'd0, x} * 16'd205;
    return prod[15:10];
  endfunction

endpackage

// ===== rtl/core/kvsq_cfg.sv =====
`timescale 1ns / 1ps
// APB-style register file holding the four configuration registers.
module kvsq_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kvsq_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [kvsq_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [kvsq_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output kvsq_pkg::kvsq_cfg_t                 cfg
);

  kvsq_pkg::kvsq_cfg_t cfg_r;
  kvsq_pkg::kvsq_reg_t idx;
  logic                wr_en;

  assign idx    = kvsq_pkg::kvsq_reg_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_low         <= kvsq_pkg::RST_ADC_LOW;
      cfg_r.adc_high        <= kvsq_pkg::RST_ADC_HIGH;
      cfg_r.update_period   <= kvsq_pkg::RST_UPDATE_PERIOD;
      cfg_r.audio_threshold <= kvsq_pkg::RST_AUDIO_THRESHOLD;
    end else if (wr_en) begin
      case (idx)
        kvsq_pkg::REG_ADC_LOW:         cfg_r.adc_low         <= pwdata[11:0];
        kvsq_pkg::REG_ADC_HIGH:        cfg_r.adc_high        <= pwdata[11:0];
        kvsq_pkg::REG_UPDATE_PERIOD:   cfg_r.update_period   <= pwdata[7:0];
        kvsq_pkg::REG_AUDIO_THRESHOLD: cfg_r.audio_threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kvsq_pkg::REG_ADC_LOW:         prdata = {20'd0, cfg_r.adc_low};
      kvsq_pkg::REG_ADC_HIGH:        prdata = {20'd0, cfg_r.adc_high};
      kvsq_pkg::REG_UPDATE_PERIOD:   prdata = {24'd0, cfg_r.update_period};
      kvsq_pkg::REG_AUDIO_THRESHOLD: prdata = {24'd0, cfg_r.audio_threshold};
      default:                       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/kvsq_smoother.sv =====
`timescale 1ns / 1ps
// Stage 1: moving-average filter state, tick counter and stage register.
module kvsq_smoother #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kvsq_pkg::kvsq_cfg_t    cfg,
  input  logic                   i_vld,
  input  logic [SAMPLE_BITS-1:0] i_sample,
  output logic                   up_free,
  input  logic                   dn_free,
  output logic                   o_vld,
  output logic [SAMPLE_BITS-1:0] o_avg,
  output logic                   o_fire
);

  localparam int QW = SAMPLE_BITS - 3;
  localparam int PW = SAMPLE_BITS + kvsq_pkg::DIV10_MUL_BITS;

  logic [SAMPLE_BITS-1:0]           avg_cur_r, avg_prev_r;
  logic [kvsq_pkg::PERIOD_BITS-1:0] tick_r;
  logic                             s_vld_r, s_fire_r;
  logic [SAMPLE_BITS-1:0]           s_avg_r;

  logic                             acc, seed, neg, fire;
  logic [SAMPLE_BITS-1:0]           base, mag, avg_nxt;
  logic [PW-1:0]                    prod;
  logic [QW-1:0]                    quo;
  logic [kvsq_pkg::PERIOD_BITS-1:0] tick_nxt;

  assign up_free = !s_vld_r || dn_free;
  assign acc     = i_vld && up_free;

  always_comb begin
    seed = (avg_cur_r == '0) && (avg_prev_r == '0);
    base = seed ? i_sample : avg_cur_r;
    neg  = i_sample < base;
    mag  = neg ? (base - i_sample) : (i_sample - base);
    // signed divide by ten, truncating toward zero: divide magnitude, reapply sign
    prod = {{kvsq_pkg::DIV10_MUL_BITS{1'b0}}, mag}
         * {{SAMPLE_BITS{1'b0}}, kvsq_pkg::DIV10_MUL};
    quo  = prod[PW-1:kvsq_pkg::DIV10_SHIFT];
    avg_nxt = neg ? (base - {3'b000, quo}) : (base + {3'b000, quo});
    fire     = tick_r >= cfg.update_period;
    tick_nxt = fire ? '0 : (tick_r + 8'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_cur_r  <= '0;
      avg_prev_r <= '0;
      tick_r     <= '0;
      s_vld_r    <= 1'b0;
    end else begin
      if (up_free) s_vld_r <= i_vld;
      if (acc) begin
        avg_prev_r <= base;
        avg_cur_r  <= avg_nxt;
        tick_r     <= tick_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s_avg_r  <= avg_nxt;
      s_fire_r <= fire;
    end
  end

  assign o_vld  = s_vld_r;
  assign o_avg  = s_avg_r;
  assign o_fire = s_fire_r;

`ifndef SYNTHESIS
  a_fire_clears_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && fire) |=> (tick_r == '0))
    else $error("tick counter not cleared after a firing beat");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> ($stable(avg_cur_r) && $stable(avg_prev_r) && $stable(tick_r)))
    else $error("filter state moved without an accepted beat");
`endif

endmodule

// ===== rtl/core/kvsq_scaler.sv =====
`timescale 1ns / 1ps
// Stage 2: clamp to the ADC window and form the scaled level product.
module kvsq_scaler #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kvsq_pkg::kvsq_cfg_t    cfg,
  input  logic                   i_vld,
  input  logic [SAMPLE_BITS-1:0] i_avg,
  input  logic                   i_fire,
  output logic                   up_free,
  input  logic                   dn_free,
  output logic                   o_vld,
  output logic [kvsq_pkg::ADC_BITS-1:0] o_smooth,
  output logic                   o_fire,
  output logic                   o_above,
  output logic [(((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 2):0] o_n,
  output logic [(((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 15):0] o_p
);

  localparam int W  = (SAMPLE_BITS > kvsq_pkg::ADC_BITS) ? SAMPLE_BITS : kvsq_pkg::ADC_BITS;
  localparam int NW = W + 3;
  localparam int PW = NW + kvsq_pkg::DIV99_MUL_BITS;

  logic          s_vld_r, s_fire_r, s_above_r;
  logic [kvsq_pkg::ADC_BITS-1:0] s_smooth_r;
  logic [NW-1:0] s_n_r;
  logic [PW-1:0] s_p_r;

  logic          acc, above;
  logic [W-1:0]  ve, lo, hi, clamped, d;
  logic [NW-1:0] n;
  logic [PW-1:0] p;

  assign up_free = !s_vld_r || dn_free;
  assign acc     = i_vld && up_free;

  always_comb begin
    ve = W'(i_avg);
    lo = W'(cfg.adc_low);
    hi = W'(cfg.adc_high);
    // high bound tested first: with crossed bounds a value above adc_high
    // lands on adc_high, anything else on adc_low
    if (ve > hi)      clamped = hi;
    else if (ve < lo) clamped = lo;
    else              clamped = ve;
    above = clamped >= lo;
    d     = clamped - lo;
    n     = {1'b0, d, 2'b00} + {3'b000, d};
    p     = {{kvsq_pkg::DIV99_MUL_BITS{1'b0}}, n} * {{NW{1'b0}}, kvsq_pkg::DIV99_MUL};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (up_free) begin
      s_vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s_smooth_r <= clamped[kvsq_pkg::ADC_BITS-1:0];
      s_fire_r   <= i_fire;
      s_above_r  <= above;
      s_n_r      <= n;
      s_p_r      <= p;
    end
  end

  assign o_vld    = s_vld_r;
  assign o_smooth = s_smooth_r;
  assign o_fire   = s_fire_r;
  assign o_above  = s_above_r;
  assign o_n      = s_n_r;
  assign o_p      = s_p_r;

endmodule

// ===== rtl/core/kvsq_level.sv =====
`timescale 1ns / 1ps
// Stage 3: quotient correction, stored level update, audio level, result register.
module kvsq_level #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kvsq_pkg::kvsq_cfg_t    cfg,
  input  logic                   i_vld,
  input  logic [kvsq_pkg::ADC_BITS-1:0] i_smooth,
  input  logic                   i_fire,
  input  logic                   i_above,
  input  logic [(((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 2):0] i_n,
  input  logic [(((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 15):0] i_p,
  output logic                   up_free,
  input  logic                   out_stall,
  output logic                   o_vld,
  output logic [kvsq_pkg::ADC_BITS-1:0]   o_smooth,
  output logic [kvsq_pkg::LEVEL_BITS-1:0] o_level,
  output logic                   o_changed,
  output logic [kvsq_pkg::AUDIO_BITS-1:0] o_audio
);

  localparam int W  = (SAMPLE_BITS > kvsq_pkg::ADC_BITS) ? SAMPLE_BITS : kvsq_pkg::ADC_BITS;
  localparam int NW = W + 3;
  localparam int PW = NW + kvsq_pkg::DIV99_MUL_BITS;
  localparam int QW = PW - kvsq_pkg::DIV99_SHIFT;
  localparam int RW = QW + 7;

  logic [kvsq_pkg::LEVEL_BITS-1:0] last_r;
  logic                            o_vld_r, o_changed_r;
  logic [kvsq_pkg::ADC_BITS-1:0]   o_smooth_r;
  logic [kvsq_pkg::LEVEL_BITS-1:0] o_level_r;
  logic [kvsq_pkg::AUDIO_BITS-1:0] o_audio_r;

  logic                            load, changed;
  logic [QW-1:0]                   q0, q;
  logic [RW-1:0]                   rem;
  logic [kvsq_pkg::LEVEL_BITS-1:0] level, last_nxt, excess;
  logic [kvsq_pkg::AUDIO_BITS-1:0] audio;

  assign up_free = !o_vld_r || !out_stall;
  assign load    = i_vld && up_free;

  always_comb begin
    q0  = i_p[PW-1:kvsq_pkg::DIV99_SHIFT];
    // estimate is low by at most one
    rem = RW'(i_n) - ({7'd0, q0} * {{QW{1'b0}}, kvsq_pkg::LEVEL_DIVISOR});
    q   = (rem >= RW'(kvsq_pkg::LEVEL_DIVISOR)) ? (q0 + 1'b1) : q0;
    level    = i_above ? q[kvsq_pkg::LEVEL_BITS-1:0] : '0;
    changed  = i_fire && (level != last_r);
    last_nxt = changed ? level : last_r;
    excess   = last_nxt - cfg.audio_threshold;
    audio    = (last_nxt < cfg.audio_threshold) ? '0 : kvsq_pkg::div5_u8(excess);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      o_vld_r <= 1'b0;
    end else begin
      if (up_free) o_vld_r <= i_vld;
      if (load)    last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_smooth_r  <= i_smooth;
      o_level_r   <= last_nxt;
      o_changed_r <= changed;
      o_audio_r   <= audio;
    end
  end

  assign o_vld     = o_vld_r;
  assign o_smooth  = o_smooth_r;
  assign o_level   = o_level_r;
  assign o_changed = o_changed_r;
  assign o_audio   = o_audio_r;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    i_vld |-> (rem < RW'(2 * kvsq_pkg::LEVEL_DIVISOR)))
    else $error("level quotient estimate off by more than one");

  a_level_tracks_store: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r |-> (o_level_r == last_r))
    else $error("result level differs from stored level");

  a_audio_below_level: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r |-> ({2'b00, o_audio_r} <= o_level_r))
    else $error("audio level exceeds volume level");
`endif

endmodule

// ===== rtl/core/knob_volume_smoother_quantizer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the knob volume smoother and quantizer.
//
// Takes one knob sample per beat and returns one result beat per sample, in
// order. Throughput is one beat per clock while out_stall is low. A sample
// accepted by the filter stage reaches out_valid after three registers: filter
// stage, clamp/scale stage, level/result register. While a result waits on
// out_stall the two upper stages still take up to two more beats, then
// in_stall rises. The filter is an EMA of weight 1/10, seeded with the first
// sample; its one-beat recurrence closes inside the first stage through a
// reciprocal multiply for the divide by ten. The smoothed value is clamped to
// [adc_low, adc_high]; every update_period+1 beats it is turned into a volume
// level (clamped - adc_low) * 5 / 99, and level_changed marks a beat that
// stored a different level. audio_level is (level - audio_threshold) / 5, or 0
// below the threshold. Registers sit at byte offsets 0x0 adc_low, 0x4
// adc_high, 0x8 update_period, 0xC audio_threshold; write them only while the
// pipe is empty.
module knob_volume_smoother_quantizer_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // sample channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [kvsq_pkg::ADC_BITS-1:0]   out_smoothed_value,
  output logic [kvsq_pkg::LEVEL_BITS-1:0] out_volume_level,
  output logic                   out_level_changed,
  output logic [kvsq_pkg::AUDIO_BITS-1:0] out_audio_level,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [kvsq_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [kvsq_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [kvsq_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                   pready
);

  localparam int W = (SAMPLE_BITS > kvsq_pkg::ADC_BITS) ? SAMPLE_BITS : kvsq_pkg::ADC_BITS;

  kvsq_pkg::kvsq_cfg_t cfg;

  // stage 1 -> stage 2
  logic                   s1_vld, s1_fire, s1_free;
  logic [SAMPLE_BITS-1:0] s1_avg;
  // stage 2 -> stage 3
  logic                   s2_vld, s2_fire, s2_above, s2_free;
  logic [kvsq_pkg::ADC_BITS-1:0] s2_smooth;
  logic [W+2:0]           s2_n;
  logic [W+15:0]          s2_p;
  logic                   s3_free;

  kvsq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kvsq_smoother #(.SAMPLE_BITS(SAMPLE_BITS)) u_smoother (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .i_vld    (in_valid),
    .i_sample (in_adc_sample),
    .up_free  (s1_free),
    .dn_free  (s2_free),
    .o_vld    (s1_vld),
    .o_avg    (s1_avg),
    .o_fire   (s1_fire)
  );

  kvsq_scaler #(.SAMPLE_BITS(SAMPLE_BITS)) u_scaler (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .i_vld    (s1_vld),
    .i_avg    (s1_avg),
    .i_fire   (s1_fire),
    .up_free  (s2_free),
    .dn_free  (s3_free),
    .o_vld    (s2_vld),
    .o_smooth (s2_smooth),
    .o_fire   (s2_fire),
    .o_above  (s2_above),
    .o_n      (s2_n),
    .o_p      (s2_p)
  );

  kvsq_level #(.SAMPLE_BITS(SAMPLE_BITS)) u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .i_vld     (s2_vld),
    .i_smooth  (s2_smooth),
    .i_fire    (s2_fire),
    .i_above   (s2_above),
    .i_n       (s2_n),
    .i_p       (s2_p),
    .up_free   (s3_free),
    .out_stall (out_stall),
    .o_vld     (out_valid),
    .o_smooth  (out_smoothed_value),
    .o_level   (out_volume_level),
    .o_changed (out_level_changed),
    .o_audio   (out_audio_level)
  );

  // a beat enters whenever stage 1 is empty or moving on
  assign in_stall = !s1_free;

endmodule
